// ===== rtl/core/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg - shared types and constants for greedy box NMS
// Box word layout, controller command and datapath status structs.
// ----------------------------------------------------------------------------
package gbn_pkg;

	localparam int MAX_BOXES = 64;
	localparam int IDX_W     = 6;
	localparam int CNT_W     = 7;
	localparam int EDGE_W    = 15;
	localparam int SCORE_W   = 16;
	localparam int BOX_W     = 4 * EDGE_W + SCORE_W;
	localparam logic [15:0] THR_RESET = 16'd26214;

	// box store read address source
	localparam logic [1:0] BOX_SEL_I    = 2'd0;
	localparam logic [1:0] BOX_SEL_J    = 2'd1;
	localparam logic [1:0] BOX_SEL_RANK = 2'd2;

	typedef struct packed {
		logic       load;
		logic [1:0] box_sel;
		logic       rank_use_j;
		logic       clr_i;
		logic       inc_i;
		logic       clr_j;
		logic       set_j_next;
		logic       inc_j;
		logic       lat_si;
		logic       clr_cnt;
		logic       cmp_rank;
		logic       wr_rank;
		logic       lat_bi;
		logic       lat_a;
		logic       geo;
		logic       mul;
		logic       uni;
		logic       prod;
		logic       mark;
		logic       emit;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic i_last;
		logic j_last;
		logic j_end;
		logic mark_i;
		logic mark_j;
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/core/greedy_box_nms.sv =====
// ----------------------------------------------------------------------------
// greedy_box_nms - greedy IoU non-maximum suppression over a set of boxes
// Loading: one box per request while s_tready is high; the final box closes
// the set. Ranking compares each box score with every loaded box (one box
// store read per compare). Suppression tests each kept box against every
// later unsuppressed rank position and waits for a free output to emit it.
// Throughput: one set at a time; s_tready is high only while loading.
// Reset (arst_n, asynchronous) empties the set and restores the threshold.
// ----------------------------------------------------------------------------
module greedy_box_nms (
	input  logic        clk,
	input  logic        arst_n,
	// slave side: one candidate box per request
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata, lowest bit up: left_edge[14:0], top_edge[29:15],
	// right_edge[44:30], bottom_edge[59:45], box_score[75:60], zero pad
	input  logic [79:0] s_tdata,
	input  logic        s_tlast,   // final_box
	// master side: one kept box per request, best first
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata, lowest bit up: kept_index[5:0], kept_left[20:6],
	// kept_top[35:21], kept_right[50:36], kept_bottom[65:51],
	// kept_score[81:66], zero pad
	output logic [87:0] m_tdata,
	output logic        m_tuser,   // overflow
	output logic        m_tlast,   // last_result
	// threshold register, Q0.16
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	gbn_pkg::cmd_t  cmd;
	gbn_pkg::stat_t st;

	// sequencer: owns state only
	gbn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// stores, counters, overlap maths and result register
	gbn_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_box    (s_tdata[gbn_pkg::BOX_W-1:0]),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser),
		.out_last  (m_tlast)
	);

	// loading and emitting never overlap
	a_no_emit_when_loading: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !cmd.emit) else $error("emit while loading");

	// a result is written only into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free) else $error("result overwritten");

	// closing a set returns to loading
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> s_tready) else $error("no return to load after finish");

endmodule

// ===== rtl/core/gbn_ram.sv =====
// ----------------------------------------------------------------------------
// gbn_ram - generic single write, single read RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/gbn_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbn_ctrl - sequencer for greedy box NMS
// Loads boxes, then steps the ranking and suppression passes.
// ----------------------------------------------------------------------------
module gbn_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_last,
	output logic          in_ready,
	input  gbn_pkg::stat_t st,
	output gbn_pkg::cmd_t  cmd
);

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_R_RDI = 5'd1;
	localparam logic [4:0] ST_R_LDI = 5'd2;
	localparam logic [4:0] ST_R_RDJ = 5'd3;
	localparam logic [4:0] ST_R_CMP = 5'd4;
	localparam logic [4:0] ST_R_WR  = 5'd5;
	localparam logic [4:0] ST_S_CHK = 5'd6;
	localparam logic [4:0] ST_S_RI  = 5'd7;
	localparam logic [4:0] ST_S_BI  = 5'd8;
	localparam logic [4:0] ST_S_JCK = 5'd9;
	localparam logic [4:0] ST_S_RJ  = 5'd10;
	localparam logic [4:0] ST_S_BJ  = 5'd11;
	localparam logic [4:0] ST_S_M1  = 5'd12;
	localparam logic [4:0] ST_S_M2  = 5'd13;
	localparam logic [4:0] ST_S_M3  = 5'd14;
	localparam logic [4:0] ST_S_M4  = 5'd15;
	localparam logic [4:0] ST_S_EMT = 5'd16;

	logic [4:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.box_sel = gbn_pkg::BOX_SEL_I;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) begin
						cmd.clr_i = 1'b1;
						state_d   = ST_R_RDI;
					end
				end
			end
			ST_R_RDI: state_d = ST_R_LDI;
			ST_R_LDI: begin
				cmd.lat_si  = 1'b1;
				cmd.clr_j   = 1'b1;
				cmd.clr_cnt = 1'b1;
				state_d     = ST_R_RDJ;
			end
			ST_R_RDJ: begin
				cmd.box_sel = gbn_pkg::BOX_SEL_J;
				state_d     = ST_R_CMP;
			end
			ST_R_CMP: begin
				cmd.cmp_rank = 1'b1;
				cmd.inc_j    = 1'b1;
				state_d      = st.j_last ? ST_R_WR : ST_R_RDJ;
			end
			ST_R_WR: begin
				cmd.wr_rank = 1'b1;
				cmd.inc_i   = 1'b1;
				if (st.i_last) begin
					cmd.clr_i = 1'b1;
					state_d   = ST_S_CHK;
				end else begin
					state_d = ST_R_RDI;
				end
			end
			ST_S_CHK: begin
				if (!st.mark_i) begin
					state_d = ST_S_RI;
				end else if (st.i_last) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					cmd.inc_i = 1'b1;
				end
			end
			ST_S_RI: begin
				cmd.box_sel = gbn_pkg::BOX_SEL_RANK;
				cmd.lat_bi  = 1'b1;
				state_d     = ST_S_BI;
			end
			ST_S_BI: begin
				cmd.lat_a      = 1'b1;
				cmd.set_j_next = 1'b1;
				state_d        = ST_S_JCK;
			end
			ST_S_JCK: begin
				cmd.rank_use_j = 1'b1;
				if (st.j_end) begin
					state_d = ST_S_EMT;
				end else if (st.mark_j) begin
					cmd.inc_j = 1'b1;
				end else begin
					state_d = ST_S_RJ;
				end
			end
			ST_S_RJ: begin
				cmd.box_sel = gbn_pkg::BOX_SEL_RANK;
				state_d     = ST_S_BJ;
			end
			ST_S_BJ: begin
				cmd.geo = 1'b1;
				state_d = ST_S_M1;
			end
			ST_S_M1: begin
				cmd.mul = 1'b1;
				state_d = ST_S_M2;
			end
			ST_S_M2: begin
				cmd.uni = 1'b1;
				state_d = ST_S_M3;
			end
			ST_S_M3: begin
				cmd.prod = 1'b1;
				state_d  = ST_S_M4;
			end
			ST_S_M4: begin
				cmd.mark  = 1'b1;
				cmd.inc_j = 1'b1;
				state_d   = ST_S_JCK;
			end
			ST_S_EMT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					if (st.i_last) begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						cmd.inc_i = 1'b1;
						state_d   = ST_S_CHK;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/core/gbn_dp.sv =====
// ----------------------------------------------------------------------------
// gbn_dp - datapath for greedy box NMS
// Box and rank stores, counters, overlap arithmetic, result register.
// ----------------------------------------------------------------------------
module gbn_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gbn_pkg::cmd_t                cmd,
	output gbn_pkg::stat_t               st,
	input  logic [gbn_pkg::BOX_W-1:0]    in_box,
	input  logic                         cfg_we,
	input  logic [15:0]                  cfg_wdata,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [87:0]                  out_data,
	output logic                         out_user,
	output logic                         out_last
);

	localparam int EW = gbn_pkg::EDGE_W;
	localparam int SW = gbn_pkg::SCORE_W;
	localparam int IW = gbn_pkg::IDX_W;
	localparam int CW = gbn_pkg::CNT_W;
	localparam int MB = gbn_pkg::MAX_BOXES;
	localparam int BOX_W_LO = 4 * EW;
	localparam int BOX_W_HI = 4 * EW + SW - 1;

	function automatic logic [EW-1:0] span(input logic [EW-1:0] lo, input logic [EW-1:0] hi);
		span = (hi > lo) ? hi - lo : '0;
	endfunction

	logic [CW-1:0] count_q, i_q, j_q;
	logic [IW-1:0] cnt_q, bi_q;
	logic          ovf_q;
	logic [15:0]   thr_q;
	logic [SW-1:0] si_q;
	logic [gbn_pkg::BOX_W-1:0] a_q;
	logic [MB-1:0] marks_q;

	logic [IW-1:0] box_raddr, rank_raddr, rank_rdata;
	logic [gbn_pkg::BOX_W-1:0] box_rdata;
	logic          box_we;

	logic [EW-1:0] w_s1, h_s1, wa_s1, ha_s1, wb_s1, hb_s1;
	logic [2*EW-1:0] inter_s2, areaa_s2, areab_s2, inter_s3;
	logic [2*EW:0]   uni_s3;
	logic [2*EW+16:0] prod_s4;

	logic [MB-1:0] rem;
	logic          out_valid_q, out_last_q, out_user_q;
	logic [87:0]   out_data_q;

	assign box_we     = cmd.load && (count_q < CW'(MB));
	assign rank_raddr = cmd.rank_use_j ? j_q[IW-1:0] : i_q[IW-1:0];

	always_comb begin
		unique case (cmd.box_sel)
			gbn_pkg::BOX_SEL_I:    box_raddr = i_q[IW-1:0];
			gbn_pkg::BOX_SEL_J:    box_raddr = j_q[IW-1:0];
			gbn_pkg::BOX_SEL_RANK: box_raddr = rank_rdata;
			default:               box_raddr = i_q[IW-1:0];
		endcase
	end

	gbn_ram #(.WIDTH(gbn_pkg::BOX_W), .DEPTH(MB)) u_box_ram (
		.clk   (clk),
		.we    (box_we),
		.waddr (count_q[IW-1:0]),
		.wdata (in_box),
		.raddr (box_raddr),
		.rdata (box_rdata)
	);

	gbn_ram #(.WIDTH(IW), .DEPTH(MB)) u_rank_ram (
		.clk   (clk),
		.we    (cmd.wr_rank),
		.waddr (cnt_q),
		.wdata (i_q[IW-1:0]),
		.raddr (rank_raddr),
		.rdata (rank_rdata)
	);

	// rank positions after i still unsuppressed
	always_comb begin
		for (int k = 0; k < MB; k++) begin
			rem[k] = (CW'(k) > i_q) && (CW'(k) < count_q) && !marks_q[k];
		end
	end

	assign st.i_last   = (i_q + CW'(1)) == count_q;
	assign st.j_last   = (j_q + CW'(1)) == count_q;
	assign st.j_end    = j_q == count_q;
	assign st.mark_i   = marks_q[i_q[IW-1:0]];
	assign st.mark_j   = marks_q[j_q[IW-1:0]];
	assign st.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			thr_q       <= gbn_pkg::THR_RESET;
			marks_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (cmd.load) begin
				if (box_we) begin
					count_q <= count_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.clr_i) begin
				i_q <= '0;
			end else if (cmd.inc_i) begin
				i_q <= i_q + CW'(1);
			end
			if (cmd.clr_j) begin
				j_q <= '0;
			end else if (cmd.set_j_next) begin
				j_q <= i_q + CW'(1);
			end else if (cmd.inc_j) begin
				j_q <= j_q + CW'(1);
			end
			if (cmd.clr_cnt) begin
				cnt_q <= '0;
			end else if (cmd.cmp_rank) begin
				if ((box_rdata[BOX_W_HI:BOX_W_LO] > si_q) ||
				    ((box_rdata[BOX_W_HI:BOX_W_LO] == si_q) && (j_q < i_q))) begin
					cnt_q <= cnt_q + IW'(1);
				end
			end
			if (cmd.mark && (uni_s3 != '0) && ({1'b0, inter_s3, 16'd0} > prod_s4)) begin
				marks_q[j_q[IW-1:0]] <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.finish) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
				marks_q <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.lat_si) begin
			si_q <= box_rdata[BOX_W_HI:BOX_W_LO];
		end
		if (cmd.lat_bi) begin
			bi_q <= rank_rdata;
		end
		if (cmd.lat_a) begin
			a_q <= box_rdata;
		end
		if (cmd.geo) begin
			w_s1  <= span((a_q[EW-1:0] > box_rdata[EW-1:0]) ? a_q[EW-1:0] : box_rdata[EW-1:0],
			              (a_q[3*EW-1:2*EW] < box_rdata[3*EW-1:2*EW]) ?
			              a_q[3*EW-1:2*EW] : box_rdata[3*EW-1:2*EW]);
			h_s1  <= span((a_q[2*EW-1:EW] > box_rdata[2*EW-1:EW]) ?
			              a_q[2*EW-1:EW] : box_rdata[2*EW-1:EW],
			              (a_q[4*EW-1:3*EW] < box_rdata[4*EW-1:3*EW]) ?
			              a_q[4*EW-1:3*EW] : box_rdata[4*EW-1:3*EW]);
			wa_s1 <= span(a_q[EW-1:0], a_q[3*EW-1:2*EW]);
			ha_s1 <= span(a_q[2*EW-1:EW], a_q[4*EW-1:3*EW]);
			wb_s1 <= span(box_rdata[EW-1:0], box_rdata[3*EW-1:2*EW]);
			hb_s1 <= span(box_rdata[2*EW-1:EW], box_rdata[4*EW-1:3*EW]);
		end
		if (cmd.mul) begin
			inter_s2 <= w_s1 * h_s1;
			areaa_s2 <= wa_s1 * ha_s1;
			areab_s2 <= wb_s1 * hb_s1;
		end
		if (cmd.uni) begin
			uni_s3   <= {1'b0, areaa_s2} + {1'b0, areab_s2} - {1'b0, inter_s2};
			inter_s3 <= inter_s2;
		end
		if (cmd.prod) begin
			prod_s4 <= thr_q * uni_s3;
		end
		if (cmd.emit) begin
			out_data_q <= {6'd0, a_q, bi_q};
			out_user_q <= ovf_q;
			out_last_q <= ~|rem;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;
	assign out_last  = out_last_q;

endmodule
